// File: hw/rtl/dpsd_pkg.sv
// Shared types, codes and sizes for the delta patch stream decoder.
package dpsd_pkg;

  // Address and size widths
  localparam int ADDR_BITS = 24;
  localparam int SIZE_BITS = ADDR_BITS + 1;
  localparam int LEN_BITS  = 32;
  localparam int WIDE_BITS = ((SIZE_BITS > LEN_BITS) ? SIZE_BITS : LEN_BITS) + 1;

  // Result queue sizing
  localparam int MAX_RES     = 3;
  localparam int FIFO_DEPTH  = 4;
  localparam int PTR_BITS    = $clog2(FIFO_DEPTH);
  localparam int CNT_BITS    = PTR_BITS + 1;

  // Configuration register indexes
  localparam logic CFG_BASE_SIZE   = 1'b0;
  localparam logic CFG_TARGET_SIZE = 1'b1;

  // Patch format bytes
  localparam logic [7:0] ESC_BYTE    = 8'hA7;
  localparam logic [7:0] OPB_MOD     = 8'hA6;
  localparam logic [7:0] OPB_INS     = 8'hA5;
  localparam logic [7:0] OPB_DEL     = 8'hA4;
  localparam logic [7:0] OPB_EQL     = 8'hA3;
  localparam logic [7:0] OPB_BKT     = 8'hA2;
  localparam logic [7:0] LEN_MAX_1B  = 8'd251;
  localparam logic [7:0] LEN_PFX_1   = 8'd252;
  localparam logic [7:0] LEN_PFX_2   = 8'd253;
  localparam logic [7:0] LEN_PFX_4   = 8'd254;
  localparam logic [8:0] LEN_BIAS_1  = 9'd253;

  // Parse phases
  localparam logic [2:0] PH_OP_START   = 3'd0;
  localparam logic [2:0] PH_OP_ESC     = 3'd1;
  localparam logic [2:0] PH_LIT        = 3'd2;
  localparam logic [2:0] PH_LIT_ESC    = 3'd3;
  localparam logic [2:0] PH_LEN_PREFIX = 3'd4;
  localparam logic [2:0] PH_LEN_SHORT  = 3'd5;
  localparam logic [2:0] PH_LEN_LONG   = 3'd6;

  // Operations
  localparam logic [2:0] OP_MOD = 3'd0;
  localparam logic [2:0] OP_INS = 3'd1;
  localparam logic [2:0] OP_DEL = 3'd2;
  localparam logic [2:0] OP_EQL = 3'd3;
  localparam logic [2:0] OP_BKT = 3'd4;

  // Result kinds
  localparam logic [1:0] K_WRITE = 2'd0;
  localparam logic [1:0] K_COPY  = 2'd1;
  localparam logic [1:0] K_DONE  = 2'd2;
  localparam logic [1:0] K_ERROR = 2'd3;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_ARG   = 3'd1;
  localparam logic [2:0] ST_TRUNC     = 3'd2;
  localparam logic [2:0] ST_BAD_LEN   = 3'd3;
  localparam logic [2:0] ST_SRC_RANGE = 3'd4;
  localparam logic [2:0] ST_TGT_RANGE = 3'd5;
  localparam logic [2:0] ST_SIZE_MIS  = 3'd6;

  // One result item
  typedef struct packed {
    logic [1:0]           kind;
    logic [ADDR_BITS-1:0] taddr;
    logic [ADDR_BITS-1:0] saddr;
    logic [LEN_BITS-1:0]  run;
    logic [7:0]           data;
    logic [2:0]           status;
    logic                 last;
  } res_t;

  // Results produced by one patch byte
  typedef struct packed {
    logic [1:0]         count;
    res_t [MAX_RES-1:0] items;
  } res_push_t;

endpackage

// File: hw/rtl/dpsd_parse.sv
// Patch byte input register, parse state and per-byte result generation.
module dpsd_parse (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          patch_valid,
  output logic                          patch_stall,
  input  logic [7:0]                    patch_byte,
  input  logic                          stream_end,
  input  logic [dpsd_pkg::SIZE_BITS-1:0] base_size,
  input  logic [dpsd_pkg::SIZE_BITS-1:0] target_size,
  input  logic                          room,
  output dpsd_pkg::res_push_t           push
);
  import dpsd_pkg::*;

  // Input register
  logic       in_full;
  logic [7:0] byte_q;
  logic       end_q;
  logic       accept;
  logic       proc;

  // Parse state
  logic [2:0]           phase, phase_next;
  logic [2:0]           op, op_next;
  logic [LEN_BITS-1:0]  acc, acc_next;
  logic [2:0]           left, left_next;
  logic [SIZE_BITS-1:0] sp, sp_next;
  logic [SIZE_BITS-1:0] tp, tp_next;
  logic                 err, err_next;
  logic                 started, started_next;

  // Decode temporaries
  logic                 zero_err;
  logic [2:0]           st;
  logic                 lit0, lit1;
  logic [7:0]           d1;
  logic [2:0]           op_eff;
  logic                 mod_w;
  logic                 w0_ok, w1_ok, copy_ok;
  logic                 run_go;
  logic [LEN_BITS-1:0]  run_len;
  logic [LEN_BITS-1:0]  acc_shift;
  logic [2:0]           left_dec;
  logic                 op_hit;
  logic [2:0]           op_code;
  logic [SIZE_BITS-1:0] tp1, sp1;
  logic [SIZE_BITS-1:0] src_room, tgt_room;
  logic                 src_bad, tgt_bad;
  logic                 term;
  logic [1:0]           term_kind;
  logic [2:0]           term_st;
  logic [1:0]           n;
  res_push_t            push_c;

  assign patch_stall = in_full && !room;
  assign accept      = patch_valid && !patch_stall;
  assign proc        = in_full && room;

  // Hold the byte until the queue has room for its results
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (proc) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_q <= patch_byte;
      end_q  <= stream_end;
    end
  end

  // Opcode lookup
  always_comb begin
    op_hit  = 1'b1;
    op_code = OP_MOD;
    case (byte_q)
      OPB_MOD: op_code = OP_MOD;
      OPB_INS: op_code = OP_INS;
      OPB_DEL: op_code = OP_DEL;
      OPB_EQL: op_code = OP_EQL;
      OPB_BKT: op_code = OP_BKT;
      default: op_hit  = 1'b0;
    endcase
  end

  assign acc_shift = {acc[LEN_BITS-9:0], byte_q};
  assign left_dec  = (left != 3'd0) ? left - 3'd1 : 3'd0;
  assign tp1       = tp + SIZE_BITS'(1);
  assign src_room  = base_size - sp;
  assign tgt_room  = target_size - tp;
  assign zero_err  = !started && ((base_size == '0) || (target_size == '0));

  always_comb begin
    phase_next   = phase;
    op_next      = op;
    acc_next     = acc;
    left_next    = left;
    sp_next      = sp;
    tp_next      = tp;
    err_next     = err;
    started_next = started;
    st           = ST_OK;
    lit0         = 1'b0;
    lit1         = 1'b0;
    d1           = byte_q;
    op_eff       = op;
    run_go       = 1'b0;
    run_len      = '0;
    w0_ok        = 1'b0;
    w1_ok        = 1'b0;
    copy_ok      = 1'b0;
    term         = 1'b0;
    term_kind    = K_DONE;
    term_st      = ST_OK;
    n            = 2'd0;
    push_c       = '0;

    // Phase decode
    if (!err && !zero_err) begin
      case (phase)
        PH_OP_ESC, PH_LIT_ESC: begin
          if (op_hit) begin
            op_next    = op_code;
            phase_next = ((op_code == OP_MOD) || (op_code == OP_INS)) ? PH_LIT : PH_LEN_PREFIX;
          end else begin
            if (phase == PH_OP_ESC) begin
              op_eff = OP_MOD;
            end
            op_next    = op_eff;
            phase_next = PH_LIT;
            lit0       = 1'b1;
            lit1       = (byte_q != ESC_BYTE);
          end
        end
        PH_LIT: begin
          if (byte_q == ESC_BYTE) begin
            phase_next = PH_LIT_ESC;
          end else begin
            lit0 = 1'b1;
          end
        end
        PH_LEN_PREFIX: begin
          if (byte_q <= LEN_MAX_1B) begin
            run_go  = 1'b1;
            run_len = LEN_BITS'(byte_q) + LEN_BITS'(1);
          end else if (byte_q == LEN_PFX_1) begin
            phase_next = PH_LEN_SHORT;
            left_next  = 3'd1;
          end else if ((byte_q == LEN_PFX_2) || (byte_q == LEN_PFX_4)) begin
            phase_next = PH_LEN_LONG;
            acc_next   = '0;
            left_next  = (byte_q == LEN_PFX_2) ? 3'd2 : 3'd4;
          end else begin
            st = ST_BAD_LEN;
          end
        end
        PH_LEN_SHORT: begin
          left_next = 3'd0;
          run_go    = 1'b1;
          run_len   = LEN_BITS'(LEN_BIAS_1) + LEN_BITS'(byte_q);
        end
        PH_LEN_LONG: begin
          acc_next  = acc_shift;
          left_next = left_dec;
          if (left_dec == 3'd0) begin
            if (acc_shift == '0) begin
              st = ST_BAD_LEN;
            end else begin
              run_go  = 1'b1;
              run_len = acc_shift;
            end
          end
        end
        default: begin
          if (byte_q == ESC_BYTE) begin
            phase_next = PH_OP_ESC;
          end else begin
            op_eff     = OP_MOD;
            op_next    = OP_MOD;
            phase_next = PH_LIT;
            lit0       = 1'b1;
          end
        end
      endcase
    end

    // Literal writes: check target room, then source room for a modify
    mod_w = (op_eff == OP_MOD);
    sp1   = sp + SIZE_BITS'(mod_w);
    if (lit0) begin
      if (tp >= target_size) begin
        st = ST_TGT_RANGE;
      end else if (mod_w && (sp >= base_size)) begin
        st = ST_SRC_RANGE;
      end else begin
        w0_ok = 1'b1;
      end
    end
    if (lit1 && w0_ok) begin
      if (tp1 >= target_size) begin
        st = ST_TGT_RANGE;
      end else if (mod_w && (sp1 >= base_size)) begin
        st = ST_SRC_RANGE;
      end else begin
        w1_ok = 1'b1;
      end
    end
    if (w0_ok) begin
      tp_next = tp + SIZE_BITS'(w0_ok) + SIZE_BITS'(w1_ok);
      if (mod_w) begin
        sp_next = sp + SIZE_BITS'(w0_ok) + SIZE_BITS'(w1_ok);
      end
    end

    // Length operations
    src_bad = (sp > base_size) || (WIDE_BITS'(run_len) > WIDE_BITS'(src_room));
    tgt_bad = (tp > target_size) || (WIDE_BITS'(run_len) > WIDE_BITS'(tgt_room));
    if (run_go) begin
      phase_next = PH_OP_START;
      case (op)
        OP_EQL: begin
          if (src_bad) begin
            st = ST_SRC_RANGE;
          end else if (tgt_bad) begin
            st = ST_TGT_RANGE;
          end else begin
            copy_ok = 1'b1;
            sp_next = sp + SIZE_BITS'(run_len);
            tp_next = tp + SIZE_BITS'(run_len);
          end
        end
        OP_DEL: begin
          if (src_bad) begin
            st = ST_SRC_RANGE;
          end else begin
            sp_next = sp + SIZE_BITS'(run_len);
          end
        end
        default: begin
          if (WIDE_BITS'(run_len) > WIDE_BITS'(sp)) begin
            st = ST_SRC_RANGE;
          end else begin
            sp_next = sp - SIZE_BITS'(run_len);
          end
        end
      endcase
    end

    // Error latch and end-of-stream check
    if (!err) begin
      started_next = 1'b1;
      if (zero_err) begin
        st = ST_BAD_ARG;
      end
      if (st != ST_OK) begin
        term      = 1'b1;
        term_kind = K_ERROR;
        term_st   = st;
        err_next  = 1'b1;
      end else if (end_q) begin
        term = 1'b1;
        if ((phase_next == PH_OP_ESC) || (phase_next == PH_LEN_PREFIX) ||
            (phase_next == PH_LEN_SHORT) || (phase_next == PH_LEN_LONG)) begin
          term_kind = K_ERROR;
          term_st   = ST_TRUNC;
        end else if (tp_next != target_size) begin
          term_kind = K_ERROR;
          term_st   = ST_SIZE_MIS;
        end
      end
    end

    // Restart the stream after its last byte
    if (end_q) begin
      phase_next   = PH_OP_START;
      op_next      = OP_MOD;
      acc_next     = '0;
      left_next    = 3'd0;
      sp_next      = '0;
      tp_next      = '0;
      err_next     = 1'b0;
      started_next = 1'b0;
    end

    // Pack results in order
    if (w0_ok) begin
      push_c.items[n].kind  = K_WRITE;
      push_c.items[n].taddr = tp[ADDR_BITS-1:0];
      push_c.items[n].data  = byte_q == ESC_BYTE || lit1 ? ESC_BYTE : byte_q;
      n = n + 2'd1;
    end
    if (w1_ok) begin
      push_c.items[n].kind  = K_WRITE;
      push_c.items[n].taddr = tp1[ADDR_BITS-1:0];
      push_c.items[n].data  = d1;
      n = n + 2'd1;
    end
    if (copy_ok) begin
      push_c.items[n].kind  = K_COPY;
      push_c.items[n].taddr = tp[ADDR_BITS-1:0];
      push_c.items[n].saddr = sp[ADDR_BITS-1:0];
      push_c.items[n].run   = run_len;
      n = n + 2'd1;
    end
    if (term) begin
      push_c.items[n].kind   = term_kind;
      push_c.items[n].status = term_st;
      n = n + 2'd1;
    end
    if (n != 2'd0) begin
      push_c.items[n - 2'd1].last = 1'b1;
    end
    push_c.count = proc ? n : 2'd0;
  end

  assign push = push_c;

  // Advance parse state when the byte is processed
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_OP_START;
      op      <= OP_MOD;
      acc     <= '0;
      left    <= 3'd0;
      sp      <= '0;
      tp      <= '0;
      err     <= 1'b0;
      started <= 1'b0;
    end else if (proc) begin
      phase   <= phase_next;
      op      <= op_next;
      acc     <= acc_next;
      left    <= left_next;
      sp      <= sp_next;
      tp      <= tp_next;
      err     <= err_next;
      started <= started_next;
    end
  end

endmodule

// File: hw/rtl/dpsd_fifo.sv
// Result queue: takes up to three results per cycle, delivers one per transfer.
module dpsd_fifo (
  input  logic                            clk,
  input  logic                            rst,
  input  dpsd_pkg::res_push_t             push,
  output logic                            room,
  output logic                            res_valid,
  input  logic                            res_stall,
  output dpsd_pkg::res_t                  head
);
  import dpsd_pkg::*;

  res_t                mem [FIFO_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                pop;

  assign res_valid = (count != '0);
  assign pop       = res_valid && !res_stall;
  assign room      = (count <= CNT_BITS'(FIFO_DEPTH - MAX_RES));
  assign head      = mem[rd_ptr];

  // Store pushed results at consecutive slots
  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RES; k++) begin
      if (2'(k) < push.count) begin
        mem[wr_ptr + PTR_BITS'(k)] <= push.items[k];
      end
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_BITS'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_BITS'(1);
      end
      count <= count + CNT_BITS'(push.count) - CNT_BITS'(pop);
    end
  end

endmodule

// File: hw/rtl/delta_patch_stream_decoder.sv
// Top level of the delta patch stream decoder: size registers, parser and result queue.
// Decodes an escape/opcode delta patch one byte per transfer into literal byte writes,
// copy runs from the source image, and a done or error result at the byte flagged
// stream_end. A byte is held in an input register, processed from there and its
// results are registered in the result queue; results leave one per transfer on the
// result channel. The block takes one byte per cycle as long as each byte causes at
// most one result and the result side does not stall; a byte with two or three results
// occupies the single-result output port for one transfer each, and the input stalls
// while the four-entry result queue has fewer than three free slots. Errors are sticky
// until the stream_end byte. Write base_size and target_size only while the block is idle.
module delta_patch_stream_decoder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          patch_valid,
  output logic                          patch_stall,
  input  logic [7:0]                    patch_byte,
  input  logic                          stream_end,
  output logic                          res_valid,
  input  logic                          res_stall,
  output logic [1:0]                    kind,
  output logic [dpsd_pkg::ADDR_BITS-1:0] target_address,
  output logic [dpsd_pkg::ADDR_BITS-1:0] source_address,
  output logic [dpsd_pkg::LEN_BITS-1:0] run_bytes,
  output logic [7:0]                    data_byte,
  output logic [2:0]                    status,
  output logic                          final_res,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [dpsd_pkg::SIZE_BITS-1:0] cfg_data
);
  import dpsd_pkg::*;

  logic [SIZE_BITS-1:0] base_size;
  logic [SIZE_BITS-1:0] target_size;
  logic                 room;
  res_push_t            push;
  res_t                 head;

  assign cfg_ready = 1'b1;

  // Size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_size   <= '0;
      target_size <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BASE_SIZE:   base_size   <= cfg_data;
        CFG_TARGET_SIZE: target_size <= cfg_data;
        default: ;
      endcase
    end
  end

  dpsd_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .patch_valid (patch_valid),
    .patch_stall (patch_stall),
    .patch_byte  (patch_byte),
    .stream_end  (stream_end),
    .base_size   (base_size),
    .target_size (target_size),
    .room        (room),
    .push        (push)
  );

  dpsd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .head      (head)
  );

  // Drive result fields from the queue head
  assign kind           = head.kind;
  assign target_address = head.taddr;
  assign source_address = head.saddr;
  assign run_bytes      = head.run;
  assign data_byte      = head.data;
  assign status         = head.status;
  assign final_res      = head.last;

endmodule

// File: sim/tb_delta_patch_stream_decoder.sv
// Self-checking testbench for the delta patch stream decoder: patch streams against a predictor.
`timescale 1ns / 100ps

module tb_delta_patch_stream_decoder;
  import dpsd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned FULL_SIZE    = 1 << ADDR_BITS;
  localparam logic [7:0]  LEN_PFX_BAD  = 8'hFF;

  // Predictor and expected command store
  class decode_scoreboard;
    logic [SIZE_BITS-1:0] base_sz;
    logic [SIZE_BITS-1:0] tgt_sz;
    logic [2:0]           phase;
    logic [2:0]           op;
    logic [31:0]          len_acc;
    logic [2:0]           len_left;
    logic [SIZE_BITS-1:0] src_pos;
    logic [SIZE_BITS-1:0] tgt_pos;
    bit                   err_latched;
    bit                   started;
    res_t                 expected_cmds[$];
    res_t                 step_res[$];
    int                   errors;
    int                   sent_bytes;
    int                   seen;

    function new();
      base_sz    = '0;
      tgt_sz     = '0;
      errors     = 0;
      sent_bytes = 0;
      seen       = 0;
      restart();
    endfunction

    function void restart();
      phase       = PH_OP_START;
      op          = OP_MOD;
      len_acc     = '0;
      len_left    = '0;
      src_pos     = '0;
      tgt_pos     = '0;
      err_latched = 1'b0;
      started     = 1'b0;
    endfunction

    function void set_size(logic idx, int unsigned val);
      if (idx == CFG_BASE_SIZE) base_sz = val[SIZE_BITS-1:0];
      else tgt_sz = val[SIZE_BITS-1:0];
    endfunction

    function int pending();
      return expected_cmds.size();
    endfunction

    function void emit(logic [1:0] k, logic [SIZE_BITS-1:0] ta, logic [SIZE_BITS-1:0] sa,
                       logic [31:0] run, logic [7:0] d, logic [2:0] st);
      res_t r;
      r.kind   = k;
      r.taddr  = ta[ADDR_BITS-1:0];
      r.saddr  = sa[ADDR_BITS-1:0];
      r.run    = run;
      r.data   = d;
      r.status = st;
      r.last   = 1'b0;
      step_res.push_back(r);
    endfunction

    // One literal byte: check room first, then write and advance
    function logic [2:0] write_lit(logic [7:0] b);
      if (tgt_pos >= tgt_sz) return ST_TGT_RANGE;
      if (op == OP_MOD && src_pos >= base_sz) return ST_SRC_RANGE;
      emit(K_WRITE, tgt_pos, '0, '0, b, ST_OK);
      tgt_pos++;
      if (op == OP_MOD) src_pos++;
      return ST_OK;
    endfunction

    // Copy, skip or back up once the length is complete
    function logic [2:0] length_op(logic [31:0] len);
      logic [33:0] s, t, l, bs, ts;
      s     = src_pos;
      t     = tgt_pos;
      l     = len;
      bs    = base_sz;
      ts    = tgt_sz;
      phase = PH_OP_START;
      if (op == OP_EQL) begin
        if (s > bs || l > bs - s) return ST_SRC_RANGE;
        if (t > ts || l > ts - t) return ST_TGT_RANGE;
        emit(K_COPY, tgt_pos, src_pos, len, 8'h00, ST_OK);
        src_pos = SIZE_BITS'(s + l);
        tgt_pos = SIZE_BITS'(t + l);
      end else if (op == OP_DEL) begin
        if (s > bs || l > bs - s) return ST_SRC_RANGE;
        src_pos = SIZE_BITS'(s + l);
      end else begin
        if (l > s) return ST_SRC_RANGE;
        src_pos = SIZE_BITS'(s - l);
      end
      return ST_OK;
    endfunction

    function logic [2:0] parse(logic [7:0] b);
      logic [2:0] st, code;
      bit         is_op;
      is_op = 1'b1;
      case (b)
        OPB_MOD: code = OP_MOD;
        OPB_INS: code = OP_INS;
        OPB_DEL: code = OP_DEL;
        OPB_EQL: code = OP_EQL;
        OPB_BKT: code = OP_BKT;
        default: begin
          code  = OP_MOD;
          is_op = 1'b0;
        end
      endcase
      case (phase)
        PH_OP_ESC, PH_LIT_ESC: begin
          if (is_op) begin
            op    = code;
            phase = (code == OP_MOD || code == OP_INS) ? PH_LIT : PH_LEN_PREFIX;
            return ST_OK;
          end
          // escaped non-opcode: literal escape byte, then the byte itself unless doubled
          if (phase == PH_OP_ESC) op = OP_MOD;
          phase = PH_LIT;
          st = write_lit(ESC_BYTE);
          if (st == ST_OK && b != ESC_BYTE) st = write_lit(b);
          return st;
        end
        PH_LIT: begin
          if (b == ESC_BYTE) begin
            phase = PH_LIT_ESC;
            return ST_OK;
          end
          return write_lit(b);
        end
        PH_LEN_PREFIX: begin
          if (b <= LEN_MAX_1B) return length_op({24'd0, b} + 32'd1);
          if (b == LEN_PFX_1) begin
            phase    = PH_LEN_SHORT;
            len_left = 3'd1;
            return ST_OK;
          end
          if (b == LEN_PFX_2 || b == LEN_PFX_4) begin
            phase    = PH_LEN_LONG;
            len_acc  = '0;
            len_left = (b == LEN_PFX_2) ? 3'd2 : 3'd4;
            return ST_OK;
          end
          return ST_BAD_LEN;
        end
        PH_LEN_SHORT: begin
          len_left = '0;
          return length_op(32'(LEN_BIAS_1) + {24'd0, b});
        end
        PH_LEN_LONG: begin
          len_acc = {len_acc[23:0], b};
          if (len_left != 0) len_left--;
          if (len_left != 0) return ST_OK;
          if (len_acc == 0) return ST_BAD_LEN;
          return length_op(len_acc);
        end
        default: begin
          if (b == ESC_BYTE) begin
            phase = PH_OP_ESC;
            return ST_OK;
          end
          op    = OP_MOD;
          phase = PH_LIT;
          return write_lit(b);
        end
      endcase
      return ST_OK;
    endfunction

    // Accepted patch byte: predict its commands and queue them
    function void note_byte(logic [7:0] b, logic e);
      logic [2:0] st;
      res_t       r;
      st = ST_OK;
      step_res.delete();
      sent_bytes++;
      if (!err_latched) begin
        if (!started) begin
          started = 1'b1;
          if (base_sz == '0 || tgt_sz == '0) st = ST_BAD_ARG;
        end
        if (st == ST_OK) st = parse(b);
        if (st != ST_OK) begin
          emit(K_ERROR, '0, '0, '0, '0, st);
          err_latched = 1'b1;
        end else if (e) begin
          if (phase inside {PH_OP_ESC, PH_LEN_PREFIX, PH_LEN_SHORT, PH_LEN_LONG})
            emit(K_ERROR, '0, '0, '0, '0, ST_TRUNC);
          else if (tgt_pos != tgt_sz)
            emit(K_ERROR, '0, '0, '0, '0, ST_SIZE_MIS);
          else
            emit(K_DONE, '0, '0, '0, '0, ST_OK);
        end
      end
      if (e) restart();
      foreach (step_res[i]) begin
        r      = step_res[i];
        r.last = (i == step_res.size() - 1);
        expected_cmds.push_back(r);
      end
    endfunction

    task report(string what);
      if (errors < 40) $display("MISMATCH result %0d: %s", seen, what);
      errors++;
    endtask

    // Accepted result: compare against the oldest expected command
    task check_result(res_t got);
      res_t want;
      seen++;
      if (expected_cmds.size() == 0) begin
        report($sformatf("unexpected, kind %0d status %0d", got.kind, got.status));
        return;
      end
      want = expected_cmds.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
      if (got.taddr !== want.taddr)
        report($sformatf("target_address %0h, expected %0h", got.taddr, want.taddr));
      if (got.saddr !== want.saddr)
        report($sformatf("source_address %0h, expected %0h", got.saddr, want.saddr));
      if (got.run !== want.run)
        report($sformatf("run_bytes %0h, expected %0h", got.run, want.run));
      if (got.data !== want.data)
        report($sformatf("data_byte %0h, expected %0h", got.data, want.data));
      if (got.status !== want.status)
        report($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.last !== want.last)
        report($sformatf("final_res %0b, expected %0b", got.last, want.last));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 patch_valid = 1'b0;
  logic                 patch_stall;
  logic [7:0]           patch_byte = '0;
  logic                 stream_end = 1'b0;
  logic                 res_valid;
  logic                 res_stall = 1'b0;
  logic [1:0]           kind;
  logic [ADDR_BITS-1:0] target_address;
  logic [ADDR_BITS-1:0] source_address;
  logic [LEN_BITS-1:0]  run_bytes;
  logic [7:0]           data_byte;
  logic [2:0]           status;
  logic                 final_res;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic                 cfg_index = 1'b0;
  logic [SIZE_BITS-1:0] cfg_data = '0;

  decode_scoreboard sb = new();

  bit          tx_idle_en = 1'b0;
  bit          rx_idle_en = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned cycle_cnt = 0;

  // Stream planning state: positions and sizes as the generator sees them
  logic [8:0]  stream_q[$];
  int unsigned plan_src, plan_tgt, plan_base, plan_tsize;
  bit          in_lit, broken;
  logic [2:0]  plan_op;

  delta_patch_stream_decoder u_top (
    .clk            (clk),
    .rst            (rst),
    .patch_valid    (patch_valid),
    .patch_stall    (patch_stall),
    .patch_byte     (patch_byte),
    .stream_end     (stream_end),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .kind           (kind),
    .target_address (target_address),
    .source_address (source_address),
    .run_bytes      (run_bytes),
    .data_byte      (data_byte),
    .status         (status),
    .final_res      (final_res),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: random stall, or a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      res_stall <= rx_idle_en && ($urandom_range(99) < 27);
    end
  end

  // Check every result transfer
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall)
      sb.check_result(res_t'{kind, target_address, source_address, run_bytes,
                             data_byte, status, final_res});
  end

  task automatic send_byte(input logic [7:0] b, input logic e);
    if (tx_idle_en)
      while ($urandom_range(99) < 27) begin
        patch_valid <= 1'b0;
        @(posedge clk);
      end
    patch_valid <= 1'b1;
    patch_byte  <= b;
    stream_end  <= e;
    @(posedge clk);
    while (patch_stall) @(posedge clk);
    sb.note_byte(b, e);
  endtask

  // Flag the last byte as stream end and send the whole stream
  task automatic send_stream();
    if (stream_q.size() == 0) stream_q.push_back({1'b0, 8'($urandom)});
    stream_q[stream_q.size()-1][8] = 1'b1;
    foreach (stream_q[i]) send_byte(stream_q[i][7:0], stream_q[i][8]);
    stream_q.delete();
  endtask

  // Hold input until every expected result is back, then let the pipe settle
  task automatic drain();
    patch_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic idx, input int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[SIZE_BITS-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_size(idx, val);
    @(posedge clk);
  endtask

  function automatic void put(input logic [7:0] b);
    stream_q.push_back({1'b0, b});
  endfunction

  function automatic void put_literal();
    logic [7:0] b;
    b = 8'($urandom);
    put(b);
    if (b == ESC_BYTE) put(b);
  endfunction

  // Encode a length with a random choice among the prefix forms that hold it
  function automatic void put_len(input int unsigned l);
    int unsigned sel;
    sel = $urandom_range(3);
    if (l <= LEN_MAX_1B + 1 && sel < 2) begin
      put(8'(l - 1));
    end else if (l >= LEN_BIAS_1 && l < LEN_BIAS_1 + 256 && sel != 3) begin
      put(LEN_PFX_1);
      put(8'(l - LEN_BIAS_1));
    end else if (l <= 65535 && sel != 3) begin
      put(LEN_PFX_2);
      put(l[15:8]);
      put(l[7:0]);
    end else begin
      put(LEN_PFX_4);
      put(l[31:24]);
      put(l[23:16]);
      put(l[15:8]);
      put(l[7:0]);
    end
  endfunction

  function automatic int unsigned pick_len(input int unsigned avail);
    int unsigned cap;
    cap = (avail < 8) ? avail : 8;
    case ($urandom_range(3))
      0: return avail;
      1: return $urandom_range(avail, 1);
      default: return $urandom_range(cap, 1);
    endcase
  endfunction

  function automatic int unsigned min2(input int unsigned a, input int unsigned b);
    return (a < b) ? a : b;
  endfunction

  // Append one operation, mostly within the image bounds
  function automatic void add_op();
    int unsigned roll, room, n, avail, l;
    bit          opened;
    roll   = $urandom_range(99);
    opened = in_lit;
    if (roll < 40) begin
      if (!in_lit || $urandom_range(2) == 0) begin
        plan_op = ($urandom_range(1) == 0) ? OP_MOD : OP_INS;
        if (plan_op == OP_INS || in_lit || $urandom_range(1) == 0) begin
          put(ESC_BYTE);
          put(plan_op == OP_MOD ? OPB_MOD : OPB_INS);
          opened = 1'b1;
        end else begin
          opened = 1'b0;
        end
      end
      room = plan_tsize - plan_tgt;
      if (plan_op == OP_MOD) room = min2(room, plan_base - plan_src);
      n = $urandom_range(4, 1);
      if (n > room) begin
        if ($urandom_range(9) != 0) n = room;
        else broken = 1'b1;
      end
      repeat (n) begin
        put_literal();
        plan_tgt++;
        if (plan_op == OP_MOD) plan_src++;
      end
      in_lit = opened || (n > 0);
    end else if (roll < 60) begin
      avail = min2(plan_base - plan_src, plan_tsize - plan_tgt);
      if (avail > 0) begin
        l = pick_len(avail);
        put(ESC_BYTE);
        put(OPB_EQL);
        put_len(l);
        plan_src += l;
        plan_tgt += l;
        in_lit = 1'b0;
      end
    end else if (roll < 72) begin
      avail = plan_base - plan_src;
      if (avail > 0) begin
        l = pick_len(avail);
        put(ESC_BYTE);
        put(OPB_DEL);
        put_len(l);
        plan_src += l;
        in_lit = 1'b0;
      end
    end else if (roll < 84) begin
      if (plan_src > 0) begin
        l = pick_len(plan_src);
        put(ESC_BYTE);
        put(OPB_BKT);
        put_len(l);
        plan_src -= l;
        in_lit = 1'b0;
      end
    end else begin
      // out of range on purpose
      case ($urandom_range(2))
        0: begin
          put(ESC_BYTE);
          put(OPB_EQL);
          put_len(min2(plan_base - plan_src, plan_tsize - plan_tgt) + $urandom_range(3, 1));
        end
        1: begin
          put(ESC_BYTE);
          put(OPB_DEL);
          put_len(plan_base - plan_src + $urandom_range(3, 1));
        end
        default: begin
          put(ESC_BYTE);
          put(OPB_BKT);
          put_len(plan_src + $urandom_range(3, 1));
        end
      endcase
      broken = 1'b1;
    end
  endfunction

  // Rewind the source and copy the rest, or insert a short rest as literals, so the target ends up full
  function automatic void fill_target();
    int unsigned r;
    r = plan_tsize - plan_tgt;
    if (r > 0 && r <= plan_base) begin
      if (plan_src > 0) begin
        put(ESC_BYTE);
        put(OPB_BKT);
        put_len(plan_src);
      end
      put(ESC_BYTE);
      put(OPB_EQL);
      put_len(r);
      plan_src = r;
      plan_tgt = plan_tsize;
      in_lit   = 1'b0;
    end else if (r > 0 && r <= 6) begin
      put(ESC_BYTE);
      put(OPB_INS);
      repeat (r) put_literal();
      plan_tgt = plan_tsize;
      plan_op  = OP_INS;
      in_lit   = 1'b1;
    end
  endfunction

  // Mostly well-formed streams; some noise, truncation and bad lengths
  function automatic void build_stream();
    int unsigned shape, nops, cut;
    plan_src = 0;
    plan_tgt = 0;
    in_lit   = 1'b0;
    broken   = 1'b0;
    plan_op  = OP_MOD;
    shape    = $urandom_range(99);
    if (shape < 12) begin
      repeat ($urandom_range(12, 1)) put(8'($urandom));
    end else begin
      nops = $urandom_range(6, 1);
      repeat (nops) if (!broken) add_op();
      if (!broken && $urandom_range(3) != 0) fill_target();
      if (shape < 28) begin
        case ($urandom_range(2))
          0: begin
            if (stream_q.size() > 1) begin
              cut = $urandom_range(stream_q.size() - 1, 1);
              while (stream_q.size() > cut) void'(stream_q.pop_back());
            end
          end
          1: begin
            put(ESC_BYTE);
            put($urandom_range(1) ? OPB_EQL : OPB_DEL);
            case ($urandom_range(2))
              0: put(LEN_PFX_BAD);
              1: begin
                put(LEN_PFX_2);
                put(8'h00);
                put(8'h00);
              end
              default: begin
                put(LEN_PFX_4);
                repeat (4) put(8'h00);
              end
            endcase
          end
          default: begin
            put(ESC_BYTE);
            if ($urandom_range(1)) begin
              put(OPB_BKT);
              put(LEN_PFX_4);
              put(8'($urandom));
            end
          end
        endcase
        repeat ($urandom_range(3)) put(8'($urandom));
      end else if (in_lit && $urandom_range(4) == 0) begin
        // escape closes the run at stream end
        put(ESC_BYTE);
      end
    end
  endfunction

  task automatic run_phase(input int unsigned bs, input int unsigned ts,
                           input int unsigned quota, input bit idle, input bit hold);
    int unsigned start;
    drain();
    write_cfg(CFG_BASE_SIZE, bs);
    write_cfg(CFG_TARGET_SIZE, ts);
    plan_base  = bs;
    plan_tsize = ts;
    tx_idle_en = idle;
    rx_idle_en = idle;
    if (hold) hold_req = 1'b1;
    start = sb.sent_bytes;
    while (sb.sent_bytes - start < quota) begin
      build_stream();
      send_stream();
      if ($urandom_range(24) == 0) drain();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;

    // Sizes still zero after reset: invalid argument on the first byte
    put(8'h00);
    send_stream();
    drain();
    write_cfg(CFG_BASE_SIZE, 8);
    write_cfg(CFG_TARGET_SIZE, 8);

    // Escape pair, escape plus literal, every opcode, one-byte lengths only; ends full
    put(ESC_BYTE); put(ESC_BYTE);
    put(ESC_BYTE); put(8'h00);
    put(8'hFF);
    put(ESC_BYTE); put(OPB_INS); put(8'h12);
    put(ESC_BYTE); put(OPB_EQL); put(8'h01);
    put(ESC_BYTE); put(OPB_BKT); put(8'h05);
    put(ESC_BYTE); put(OPB_DEL); put(8'h00);
    put(ESC_BYTE); put(OPB_MOD); put(8'h55);
    put(ESC_BYTE);
    send_stream();

    // Dangling escape at the stream end byte
    put(ESC_BYTE);
    send_stream();

    // Bad length prefix, then a byte that is ignored
    put(ESC_BYTE); put(OPB_EQL); put(LEN_PFX_BAD); put(8'h00);
    send_stream();

    run_phase(16, 16, 60, 1'b1, 1'b1);
    run_phase(300, 200, 60, 1'b0, 1'b0);
    run_phase(1, 1, 25, 1'b1, 1'b0);
    run_phase(FULL_SIZE, FULL_SIZE, 60, 1'b1, 1'b0);
    run_phase(0, 40, 6, 1'b1, 1'b0);
    run_phase(40, 0, 6, 1'b1, 1'b0);
    run_phase(FULL_SIZE, 1, 30, 1'b1, 1'b0);
    run_phase(64, FULL_SIZE, 40, 1'b1, 1'b0);
    run_phase(100, 100, 70, 1'b1, 1'b0);
    drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
